[rtl/core/spe_pkg.sv]
// Package for the shortest path engine: sizes, command and status codes, FSM state type.
// No dependencies.
`timescale 1ns / 1ps
package spe_pkg;
   localparam int NodeCapacityDefault = 64;
   localparam int EdgeCapacityDefault = 1024;
   localparam int WeightBitsDefault   = 16;
   localparam int LengthBitsDefault   = 24;

   localparam int KeyBits    = 32;
   localparam int CmdBits    = 3;
   localparam int StatusBits = 3;
   localparam int InWeightBits = 16;
   localparam int InSlotBits = 6;
   localparam int OutLenBits = 24;
   localparam int CountBits  = 7;

   localparam logic [CmdBits-1:0] CMD_CLEAR = 3'd0;
   localparam logic [CmdBits-1:0] CMD_ADD_NODE = 3'd1;
   localparam logic [CmdBits-1:0] CMD_ADD_EDGE = 3'd2;
   localparam logic [CmdBits-1:0] CMD_RUN = 3'd3;
   localparam logic [CmdBits-1:0] CMD_READ = 3'd4;

   localparam logic [StatusBits-1:0] ST_OK = 3'd0;
   localparam logic [StatusBits-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [StatusBits-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [StatusBits-1:0] ST_NODE_FULL = 3'd3;
   localparam logic [StatusBits-1:0] ST_EDGE_FULL = 3'd4;
   localparam logic [StatusBits-1:0] ST_EMPTY = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOOK_A,     // scan key table for node_key
      S_LOOK_B,     // scan key table for other_key
      S_EDGE_WR1,
      S_EDGE_WR2,
      S_INIT,       // reset per-node run state for all slots
      S_MIN,        // scan nodes for least unvisited finite distance
      S_EDGE_RD,    // stream all edge slots, relaxing those of the extracted node
      S_EDGE_CHK,
      S_READ,
      S_READ2,
      S_RESP
   } state_type;
endpackage

[rtl/core/shortest_path_engine.sv]
// Keyed graph store with a single-source shortest path sequencer. Each request gives one
// response. Add node and add edge scan the key table once per key. A run looks up its
// source key, then sweeps all node slots, then per extraction scans the node run memory
// and streams every stored edge slot, relaxing each slot that the extracted node owns,
// all bound by the single read port of each memory.
`timescale 1ns / 1ps
module shortest_path_engine
   import spe_pkg::*;
#(
   parameter int NodeCapacity = NodeCapacityDefault,
   parameter int EdgeCapacity = EdgeCapacityDefault,
   parameter int WeightBits = WeightBitsDefault,
   parameter int LengthBits = LengthBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_extract_limit,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CmdBits-1:0]      req_command,
   input  logic [KeyBits-1:0]      req_node_key,
   input  logic [KeyBits-1:0]      req_other_key,
   input  logic [InWeightBits-1:0] req_edge_weight,
   input  logic [InSlotBits-1:0]   req_read_slot,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [StatusBits-1:0]   rsp_status,
   output logic [KeyBits-1:0]      rsp_slot_key,
   output logic [OutLenBits-1:0]   rsp_path_length,
   output logic                    rsp_reachable,
   output logic [InSlotBits-1:0]   rsp_previous_slot,
   output logic                    rsp_has_previous,
   output logic [CountBits-1:0]    rsp_nodes_in_use
);
   localparam int SlotBits = $clog2(NodeCapacity);
   localparam int EdgeBits = $clog2(EdgeCapacity);
   localparam int NCntBits = $clog2(NodeCapacity + 1);
   localparam int ECntBits = $clog2(EdgeCapacity + 1);
   localparam int RunBits = LengthBits + SlotBits + 3;
   localparam int EWordBits = 2*SlotBits + WeightBits;
   localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};

   state_type state_ff, state_in;
   logic [7:0] limit_ff;
   logic [NCntBits-1:0] ntot_ff, ntot_in;
   logic [ECntBits-1:0] etot_ff, etot_in;
   logic [CmdBits-1:0] cmd_ff;
   logic [KeyBits-1:0] keya_ff, keyb_ff;
   logic [WeightBits-1:0] wt_ff;
   logic [InSlotBits-1:0] rslot_ff;
   logic [NCntBits-1:0] idx_ff, idx_in;      // node scan index
   logic [ECntBits-1:0] eidx_ff, eidx_in;    // edge scan index
   logic rd_pend_ff, rd_pend_in;              // read issued last cycle
   logic [SlotBits-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic found_ff, found_in;
   logic [SlotBits-1:0] u_ff, u_in;
   logic [LengthBits-1:0] ulen_ff, ulen_in;
   logic [7:0] ext_ff, ext_in;
   logic [StatusBits-1:0] st_ff, st_in;
   logic rsp_valid_ff;
   logic [StatusBits-1:0] o_st_ff;
   logic [KeyBits-1:0] o_key_ff;
   logic [OutLenBits-1:0] o_len_ff;
   logic o_reach_ff, o_hp_ff;
   logic [InSlotBits-1:0] o_prev_ff;
   logic load_rsp;
   logic [StatusBits-1:0] ld_st;
   logic ld_rd;

   // memory ports
   logic key_we;
   logic [SlotBits-1:0] key_addr;
   logic [KeyBits-1:0] key_rdata;
   logic run_we;
   logic [SlotBits-1:0] run_waddr, run_raddr;
   logic [RunBits-1:0] run_wdata, run_rdata;
   logic e_we;
   logic [EdgeBits-1:0] e_addr;
   logic [EWordBits-1:0] e_wdata, e_rdata;

   spe_node_mem #(.NodeCapacity(NodeCapacity), .LengthBits(LengthBits)) u_node (
      .clock, .key_we, .key_addr, .key_wdata(keya_ff), .key_rdata,
      .run_we, .run_waddr, .run_wdata, .run_raddr, .run_rdata);

   spe_edge_mem #(.EdgeCapacity(EdgeCapacity), .NodeCapacity(NodeCapacity),
      .WeightBits(WeightBits)) u_edge (
      .clock, .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));

   // run word fields from memory
   logic [LengthBits-1:0] r_len;
   logic r_fin, r_done, r_hp;
   logic [SlotBits-1:0] r_prev;
   assign {r_len, r_fin, r_done, r_hp, r_prev} = run_rdata;
   logic [SlotBits-1:0] e_own, e_tgt;
   logic [WeightBits-1:0] e_w;
   assign {e_own, e_tgt, e_w} = e_rdata;

   // previous slot index and its read target
   logic [SlotBits-1:0] idx_prev;
   assign idx_prev = idx_ff[SlotBits-1:0] - SlotBits'(1);
   logic idx_end;
   assign idx_end = (idx_ff >= ntot_ff);
   logic [LengthBits:0] cand_sum;
   assign cand_sum = {1'b0, ulen_ff} + (LengthBits+1)'(e_w);
   logic [LengthBits-1:0] cand;
   assign cand = cand_sum[LengthBits] ? LenMax : cand_sum[LengthBits-1:0];
   logic [7:0] ext_next;
   assign ext_next = ext_ff + 8'd1;

   // edge check stage: registered edge word target read of run memory
   logic [SlotBits-1:0] ev_ff;
   logic [LengthBits-1:0] ec_ff;

   // predecessor of the candidate minimum, captured along with it
   logic hp_u_ff;
   logic [SlotBits-1:0] prev_u_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            priority case (req_command)
               CMD_CLEAR: state_in = S_RESP;
               CMD_ADD_NODE, CMD_ADD_EDGE, CMD_RUN: state_in = S_LOOK_A;
               CMD_READ: state_in = S_READ;
               default: state_in = S_RESP;
            endcase
         end
         S_LOOK_A: if (rd_pend_ff && key_rdata == keya_ff) begin
            priority case (cmd_ff)
               CMD_ADD_NODE: state_in = S_RESP;
               CMD_ADD_EDGE: state_in = S_LOOK_B;
               default: state_in = S_INIT;
            endcase
         end else if (!rd_pend_ff && idx_end) begin
            state_in = (cmd_ff == CMD_ADD_NODE) ? S_EDGE_WR1 : S_RESP;
         end
         S_LOOK_B: if (rd_pend_ff && key_rdata == keyb_ff) begin
            state_in = S_EDGE_WR1;
         end else if (!rd_pend_ff && idx_end) state_in = S_RESP;
         S_EDGE_WR1: state_in = (cmd_ff == CMD_ADD_NODE) ? S_RESP : S_EDGE_WR2;
         S_EDGE_WR2: state_in = S_RESP;
         S_INIT: if (idx_ff == NCntBits'(NodeCapacity - 1)) state_in = S_MIN;
         S_MIN: if (!rd_pend_ff && idx_end) begin
            if (!found_ff) state_in = S_RESP;
            else if (limit_ff != 8'd0 && ext_next >= limit_ff) state_in = S_RESP;
            else state_in = S_EDGE_RD;
         end
         S_EDGE_RD: if (!rd_pend_ff && eidx_ff >= etot_ff) state_in = S_MIN;
            else if (rd_pend_ff && e_own == u_ff) state_in = S_EDGE_CHK;
         S_EDGE_CHK: if (rd_pend_ff) state_in = S_EDGE_RD;
         S_READ: state_in = S_READ2;
         S_READ2: state_in = S_RESP;
         S_RESP: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ntot_in = ntot_ff; etot_in = etot_ff; idx_in = idx_ff; eidx_in = eidx_ff;
      rd_pend_in = 1'b0; sa_in = sa_ff; sb_in = sb_ff; found_in = found_ff;
      u_in = u_ff; ulen_in = ulen_ff; ext_in = ext_ff; st_in = st_ff;
      key_we = 1'b0; key_addr = idx_ff[SlotBits-1:0];
      run_we = 1'b0; run_waddr = idx_ff[SlotBits-1:0]; run_raddr = idx_ff[SlotBits-1:0];
      run_wdata = '0;
      e_we = 1'b0; e_addr = eidx_ff[EdgeBits-1:0]; e_wdata = '0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0; eidx_in = '0; st_in = ST_OK; found_in = 1'b0; ext_in = '0;
            if (req_valid && req_command == CMD_CLEAR) begin
               ntot_in = '0; etot_in = '0;
            end
         end
         S_LOOK_A, S_LOOK_B: begin
            if (rd_pend_ff && key_rdata == ((state_ff == S_LOOK_A) ? keya_ff : keyb_ff)) begin
               if (state_ff == S_LOOK_A) sa_in = idx_prev; else sb_in = idx_prev;
               if (cmd_ff == CMD_ADD_NODE) st_in = ST_DUPLICATE;
               idx_in = '0;
            end else if (!rd_pend_ff) begin
               if (idx_end) begin
                  if (cmd_ff != CMD_ADD_NODE) st_in = ST_NOT_FOUND;
                  else if (ntot_ff >= NCntBits'(NodeCapacity)) st_in = ST_NODE_FULL;
               end else begin
                  rd_pend_in = 1'b1; idx_in = idx_ff + NCntBits'(1);
               end
            end
         end
         S_EDGE_WR1: begin
            if (cmd_ff == CMD_ADD_NODE) begin
               if (st_ff == ST_OK) begin
                  key_we = 1'b1; key_addr = ntot_ff[SlotBits-1:0];
                  // new slot starts with no run result
                  run_we = 1'b1; run_waddr = ntot_ff[SlotBits-1:0];
                  ntot_in = ntot_ff + NCntBits'(1);
               end
            end else if (etot_ff + ECntBits'(2) > ECntBits'(EdgeCapacity)
                         || etot_ff > ECntBits'(EdgeCapacity - 2)) begin
               st_in = ST_EDGE_FULL;
            end else begin
               e_we = 1'b1; e_addr = etot_ff[EdgeBits-1:0]; e_wdata = {sa_ff, sb_ff, wt_ff};
            end
         end
         S_EDGE_WR2: if (st_ff == ST_OK) begin
            e_we = 1'b1; e_addr = etot_ff[EdgeBits-1:0] + EdgeBits'(1);
            e_wdata = {sb_ff, sa_ff, wt_ff};
            etot_in = etot_ff + ECntBits'(2);
         end
         S_INIT: begin
            run_we = 1'b1;
            run_wdata = {LengthBits'(0), (idx_ff[SlotBits-1:0] == sa_ff), 1'b0, 1'b0,
                         SlotBits'(0)};
            idx_in = idx_ff + NCntBits'(1);
            if (idx_ff == NCntBits'(NodeCapacity - 1)) idx_in = '0;
         end
         S_MIN: begin
            if (rd_pend_ff && r_fin && !r_done && (!found_ff || r_len < ulen_ff)) begin
               found_in = 1'b1; u_in = idx_prev; ulen_in = r_len;
            end
            if (!rd_pend_ff) begin
               if (idx_end) begin
                  if (found_ff) begin
                     // mark extracted node done; length and predecessor already final
                     run_we = 1'b1; run_waddr = u_ff;
                     ext_in = ext_next;
                  end
                  eidx_in = '0; idx_in = '0;
               end else begin
                  rd_pend_in = 1'b1; idx_in = idx_ff + NCntBits'(1);
               end
            end
            run_wdata = {ulen_ff, 1'b1, 1'b1, hp_u_ff, prev_u_ff};
         end
         S_EDGE_RD: begin
            found_in = 1'b0;
            if (!rd_pend_ff && eidx_ff < etot_ff) begin
               rd_pend_in = 1'b1; eidx_in = eidx_ff + ECntBits'(1);
            end
            run_raddr = e_tgt;
         end
         S_EDGE_CHK: begin
            run_raddr = ev_ff;
            if (!rd_pend_ff) rd_pend_in = 1'b1;
            else if (!r_done && (!r_fin || ec_ff < r_len)) begin
               run_we = 1'b1; run_waddr = ev_ff;
               run_wdata = {ec_ff, 1'b1, 1'b0, 1'b1, u_ff};
            end
         end
         S_READ: begin
            key_addr = rslot_ff[SlotBits-1:0]; run_raddr = rslot_ff[SlotBits-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MIN && rd_pend_ff && r_fin && !r_done
          && (!found_ff || r_len < ulen_ff)) begin
         hp_u_ff <= r_hp; prev_u_ff <= r_prev;
      end
      if (state_ff == S_EDGE_RD) begin
         ev_ff <= e_tgt; ec_ff <= cand;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff <= req_command; keya_ff <= req_node_key; keyb_ff <= req_other_key;
         wt_ff <= WeightBits'(req_edge_weight); rslot_ff <= req_read_slot;
      end
      if (state_ff == S_LOOK_A && cmd_ff == CMD_ADD_NODE) keyb_ff <= keya_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; limit_ff <= '0; ntot_ff <= '0; etot_ff <= '0;
         rd_pend_ff <= 1'b0; rsp_valid_ff <= 1'b0; idx_ff <= '0; eidx_ff <= '0;
         found_ff <= 1'b0; ext_ff <= '0; st_ff <= ST_OK;
      end else begin
         state_ff <= state_in; ntot_ff <= ntot_in; etot_ff <= etot_in;
         idx_ff <= idx_in; eidx_ff <= eidx_in; rd_pend_ff <= rd_pend_in;
         found_ff <= found_in; ext_ff <= ext_in; st_ff <= st_in;
         if (csr_valid && csr_ready) limit_ff <= csr_extract_limit;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      sa_ff <= sa_in; sb_ff <= sb_in; u_ff <= u_in; ulen_ff <= ulen_in;
   end

   // response register
   logic read_ok;
   assign read_ok = (NCntBits'(rslot_ff) < ntot_ff) && (32'(rslot_ff) < 32'(NodeCapacity));
   assign load_rsp = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);
   assign ld_rd = (cmd_ff == CMD_READ) && read_ok;
   always_comb begin
      ld_st = st_ff;
      if (cmd_ff == CMD_READ && !read_ok) ld_st = ST_EMPTY;
   end
   logic [KeyBits-1:0] rd_key_ff;
   logic [RunBits-1:0] rd_run_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_READ2) begin
         rd_key_ff <= key_rdata; rd_run_ff <= run_rdata;
      end
      if (load_rsp) begin
         o_st_ff <= ld_st;
         o_key_ff <= ld_rd ? rd_key_ff : '0;
         o_len_ff <= ld_rd ? OutLenBits'(rd_run_ff[RunBits-1 -: LengthBits]) : '0;
         o_reach_ff <= ld_rd & rd_run_ff[SlotBits+2];
         o_hp_ff <= ld_rd & rd_run_ff[SlotBits];
         o_prev_ff <= (ld_rd & rd_run_ff[SlotBits]) ?
                      InSlotBits'(rd_run_ff[SlotBits-1:0]) : '0;
      end
   end

   logic [CountBits-1:0] o_cnt_ff;
   always_ff @(posedge clock) if (load_rsp) o_cnt_ff <= CountBits'(ntot_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = o_st_ff;
   assign rsp_slot_key = o_key_ff;
   assign rsp_path_length = o_len_ff;
   assign rsp_reachable = o_reach_ff;
   assign rsp_previous_slot = o_prev_ff;
   assign rsp_has_previous = o_hp_ff;
   assign rsp_nodes_in_use = o_cnt_ff;

   a_ntot_cap: assert property (@(posedge clock) disable iff (reset)
      ntot_ff <= NCntBits'(NodeCapacity)) else $error("node count over capacity");
   a_etot_cap: assert property (@(posedge clock) disable iff (reset)
      etot_ff <= ECntBits'(EdgeCapacity)) else $error("edge count over capacity");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> state_ff == S_IDLE) else $error("response without return to idle");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("request taken while busy");
   a_ext_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EDGE_RD && limit_ff != 8'd0) |-> ext_ff < limit_ff)
      else $error("relaxing past extraction limit");
endmodule

[rtl/core/spe_node_mem.sv]
// Node memory: key table plus per-node run state (length, finite, done, predecessor).
// Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_node_mem
   import spe_pkg::*;
#(
   parameter int NodeCapacity = NodeCapacityDefault,
   parameter int LengthBits = LengthBitsDefault,
   localparam int SlotBits = $clog2(NodeCapacity)
) (
   input  logic                  clock,
   input  logic                  key_we,
   input  logic [SlotBits-1:0]   key_addr,
   input  logic [KeyBits-1:0]    key_wdata,
   output logic [KeyBits-1:0]    key_rdata,
   input  logic                  run_we,
   input  logic [SlotBits-1:0]   run_waddr,
   input  logic [LengthBits+SlotBits+2:0] run_wdata,
   input  logic [SlotBits-1:0]   run_raddr,
   output logic [LengthBits+SlotBits+2:0] run_rdata
);
   // run word: {len, finite, done, has_prev, prev}
   logic [KeyBits-1:0] key_mem [NodeCapacity];
   logic [LengthBits+SlotBits+2:0] run_mem [NodeCapacity];

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_addr] <= key_wdata;
      key_rdata <= key_mem[key_addr];
   end

   always_ff @(posedge clock) begin
      if (run_we) run_mem[run_waddr] <= run_wdata;
      run_rdata <= run_mem[run_raddr];
   end
endmodule

[rtl/core/spe_edge_mem.sv]
// Edge slot memory: owner, target and weight per directed slot.
// Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_edge_mem
   import spe_pkg::*;
#(
   parameter int EdgeCapacity = EdgeCapacityDefault,
   parameter int NodeCapacity = NodeCapacityDefault,
   parameter int WeightBits = WeightBitsDefault,
   localparam int EdgeBits = $clog2(EdgeCapacity),
   localparam int SlotBits = $clog2(NodeCapacity),
   localparam int WordBits = 2*SlotBits + WeightBits
) (
   input  logic                clock,
   input  logic                we,
   input  logic [EdgeBits-1:0] addr,
   input  logic [WordBits-1:0] wdata,
   output logic [WordBits-1:0] rdata
);
   logic [WordBits-1:0] mem [EdgeCapacity];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
